FILE: design/fac_pkg.sv
// Shared types, constants and scaling factors for the follower acceleration command block.
package fac_pkg;

  typedef struct packed {
    logic [13:0]        lead_vel;
    logic [13:0]        own_vel;
    logic signed [11:0] leader_accel;
    logic [15:0]        gap_distance;
    logic [13:0]        brake_pedal;
    logic [13:0]        accel_pedal;
  } fac_in_t;

  typedef struct packed {
    logic signed [11:0] accel_command;
    logic               limited;
  } fac_out_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_IDX_DESIRED_GAP = 2'd0;
  localparam logic [1:0] CFG_IDX_UPPER_LIMIT = 2'd1;
  localparam logic [1:0] CFG_IDX_LOWER_LIMIT = 2'd2;
  localparam int         CFG_W               = 16;

  localparam logic [15:0]        DESIRED_GAP_RST = 16'd1500;
  localparam logic signed [11:0] UPPER_LIMIT_RST = 12'sd300;
  localparam logic signed [11:0] LOWER_LIMIT_RST = -12'sd500;

  // Datapath widths; internal value is in units of 4e-7 of 0.01 m/s^2
  localparam int SUM_W       = 21;
  localparam int BASE_PROD_W = 39;
  localparam int VAL_W       = 42;
  localparam int TERM_W      = 31;
  localparam int FF_W        = 32;
  localparam int LIM_PROD_W  = 35;
  localparam int DIV_IN_W    = 28;
  localparam int DIV_SHIFT   = 5;
  localparam int RECIP_W     = 29;
  localparam int PROD_W      = DIV_IN_W + RECIP_W;
  localparam int RECIP_SHIFT = 45;
  localparam int QUO_W       = 12;

  // Gap error band limits in cm
  localparam logic signed [16:0] BAND_HI = 17'sd1000;
  localparam logic signed [16:0] BAND_LO = -17'sd500;

  // Pedal thresholds in 1/10000
  localparam logic [13:0] PEDAL_DEAD = 14'd1000;
  localparam logic [13:0] PEDAL_FULL = 14'd5000;

  // Gain scale: s * 62500 gives the feedback term
  localparam logic [16:0] GAIN_SCALE = 17'd62500;

  // Feedforward coefficients: c1 * p + c2 * p^2
  localparam logic [16:0] C1_BRAKE_QUAD = 17'd45000;
  localparam logic [16:0] C1_BRAKE_LIN  = 17'd75000;
  localparam logic [16:0] C1_ACCEL      = 17'd30000;
  localparam logic [2:0]  C2_BRAKE_QUAD = 3'd6;
  localparam logic [2:0]  C2_ACCEL      = 3'd3;

  // One output LSB and half of it, in internal units; 2500000 = 32 * 78125
  localparam logic [22:0]       UNIT_SCALE = 23'd2500000;
  localparam logic [VAL_W-1:0]  HALF_UNIT  = VAL_W'(1250000);
  // ceil(2^45 / 78125), exact for every dividend below 2^28
  localparam logic [RECIP_W-1:0] RECIP_78125 = 29'd450359963;

  typedef struct packed {
    logic valid;
    logic sub;
  } front_ctl_t;

  typedef struct packed {
    logic valid;
    logic hi_hit;
    logic lo_hit;
    logic neg;
  } lim_ctl_t;

endpackage

FILE: design/fac_front.sv
// Front stages: gap error, banded gain sum, pedal square, then feedback and feedforward products.
module fac_front import fac_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  fac_in_t                   in_data,
  input  logic [15:0]               desired_gap,
  output front_ctl_t                ctl,
  output logic signed [VAL_W-1:0]   base,
  output logic [TERM_W-1:0]         lin_term,
  output logic [TERM_W-1:0]         sq_term
);

  typedef enum logic [1:0] {FF_NONE, FF_BRAKE_QUAD, FF_BRAKE_LIN, FF_ACCEL} ff_mode_t;

  // Stage 1 signals
  logic signed [16:0]      gap_err;
  logic signed [14:0]      speed_diff;
  logic signed [SUM_W-1:0] a_ext, dv_ext, e_ext, sum_nxt;
  logic                    in_band;
  ff_mode_t                mode_nxt;
  logic [13:0]             pedal_nxt;

  logic                    v1_r;
  logic signed [SUM_W-1:0] sum1_r;
  ff_mode_t                mode1_r;
  logic [13:0]             pedal1_r;
  logic [27:0]             psq1_r;

  // Stage 2 signals
  logic signed [BASE_PROD_W-1:0] base_prod;
  logic signed [VAL_W-1:0]       base_ext, base_nxt;
  logic [16:0]                   c1;
  logic [2:0]                    c2;

  logic                    v2_r;
  logic                    sub2_r;
  logic signed [VAL_W-1:0] base2_r;
  logic [TERM_W-1:0]       lin2_r, sq2_r;

  always_comb begin
    gap_err    = signed'({1'b0, in_data.gap_distance}) - signed'({1'b0, desired_gap});
    speed_diff = signed'({1'b0, in_data.lead_vel}) - signed'({1'b0, in_data.own_vel});
    in_band    = (gap_err < BAND_HI) && (gap_err > BAND_LO);
    a_ext      = {{(SUM_W-12){in_data.leader_accel[11]}}, in_data.leader_accel};
    dv_ext     = {{(SUM_W-15){speed_diff[14]}}, speed_diff};
    e_ext      = {{(SUM_W-17){gap_err[16]}}, gap_err};
    if (in_band) begin
      sum_nxt = (a_ext <<< 2) + (dv_ext <<< 1) + (e_ext <<< 1);
    end else begin
      sum_nxt = (a_ext <<< 1) + dv_ext + (e_ext <<< 2);
    end
    // a light brake touch still blocks the accelerator term
    mode_nxt  = FF_NONE;
    pedal_nxt = in_data.brake_pedal;
    if (in_data.brake_pedal != 14'd0) begin
      if (in_data.brake_pedal > PEDAL_DEAD && in_data.brake_pedal < PEDAL_FULL) begin
        mode_nxt = FF_BRAKE_QUAD;
      end else if (in_data.brake_pedal >= PEDAL_FULL) begin
        mode_nxt = FF_BRAKE_LIN;
      end
    end else if (in_data.accel_pedal > PEDAL_DEAD) begin
      mode_nxt  = FF_ACCEL;
      pedal_nxt = in_data.accel_pedal;
    end
  end

  always_comb begin
    base_prod = sum1_r * signed'({1'b0, GAIN_SCALE});
    base_ext  = {{(VAL_W-BASE_PROD_W){base_prod[BASE_PROD_W-1]}}, base_prod};
    // scale a negative feedback sum by four
    base_nxt  = base_prod[BASE_PROD_W-1] ? (base_ext <<< 2) : base_ext;
    case (mode1_r)
      FF_BRAKE_QUAD: begin c1 = C1_BRAKE_QUAD; c2 = C2_BRAKE_QUAD; end
      FF_BRAKE_LIN:  begin c1 = C1_BRAKE_LIN;  c2 = 3'd0;          end
      FF_ACCEL:      begin c1 = C1_ACCEL;      c2 = C2_ACCEL;      end
      default:       begin c1 = 17'd0;         c2 = 3'd0;          end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
    sum1_r   <= sum_nxt;
    mode1_r  <= mode_nxt;
    pedal1_r <= pedal_nxt;
    psq1_r   <= pedal_nxt * pedal_nxt;
    base2_r  <= base_nxt;
    lin2_r   <= pedal1_r * c1;
    sq2_r    <= psq1_r * c2;
    sub2_r   <= (mode1_r == FF_BRAKE_QUAD) || (mode1_r == FF_BRAKE_LIN);
  end

  assign ctl.valid = v2_r;
  assign ctl.sub   = sub2_r;
  assign base      = base2_r;
  assign lin_term  = lin2_r;
  assign sq_term   = sq2_r;

endmodule

FILE: design/fac_limit.sv
// Middle stages: add feedforward, compare with scaled limits, prepare the rounding dividend.
module fac_limit import fac_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  front_ctl_t                ctl_in,
  input  logic signed [VAL_W-1:0]   base,
  input  logic [TERM_W-1:0]         lin_term,
  input  logic [TERM_W-1:0]         sq_term,
  input  logic signed [11:0]        upper_limit,
  input  logic signed [11:0]        lower_limit,
  output lim_ctl_t                  ctl_out,
  output logic [DIV_IN_W-1:0]       dividend
);

  logic [FF_W-1:0]              ff;
  logic signed [VAL_W-1:0]      ff_ext, val_nxt;
  logic signed [LIM_PROD_W-1:0] hi_prod, lo_prod;

  logic                    v3_r;
  logic signed [VAL_W-1:0] val3_r;
  logic signed [VAL_W-1:0] hi_scl_r, lo_scl_r;

  logic                    hi_hit, lo_hit, neg;
  logic [VAL_W-1:0]        rnd_sum;

  lim_ctl_t                ctl4_r;
  logic [DIV_IN_W-1:0]     div4_r;

  always_comb begin
    ff      = {1'b0, lin_term} + {1'b0, sq_term};
    ff_ext  = signed'({{(VAL_W-FF_W){1'b0}}, ff});
    val_nxt = ctl_in.sub ? (base - ff_ext) : (base + ff_ext);
    hi_prod = upper_limit * signed'({1'b0, UNIT_SCALE});
    lo_prod = lower_limit * signed'({1'b0, UNIT_SCALE});
  end

  always_comb begin
    // upper limit wins even when the limits cross
    hi_hit  = val3_r > hi_scl_r;
    lo_hit  = !hi_hit && (val3_r < lo_scl_r);
    neg     = val3_r[VAL_W-1];
    // magnitude plus half an LSB, ties go away from zero
    rnd_sum = neg ? (HALF_UNIT - unsigned'(val3_r)) : (unsigned'(val3_r) + HALF_UNIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r         <= 1'b0;
      ctl4_r.valid <= 1'b0;
    end else begin
      v3_r         <= ctl_in.valid;
      ctl4_r.valid <= v3_r;
    end
    val3_r        <= val_nxt;
    hi_scl_r      <= {{(VAL_W-LIM_PROD_W){hi_prod[LIM_PROD_W-1]}}, hi_prod};
    lo_scl_r      <= {{(VAL_W-LIM_PROD_W){lo_prod[LIM_PROD_W-1]}}, lo_prod};
    ctl4_r.hi_hit <= hi_hit;
    ctl4_r.lo_hit <= lo_hit;
    ctl4_r.neg    <= neg;
    div4_r        <= rnd_sum[DIV_IN_W+DIV_SHIFT-1:DIV_SHIFT];
  end

  assign ctl_out  = ctl4_r;
  assign dividend = div4_r;

endmodule

FILE: design/fac_round.sv
// Final stages: reciprocal divide to the output LSB, sign and limit selection.
module fac_round import fac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lim_ctl_t              ctl_in,
  input  logic [DIV_IN_W-1:0]   dividend,
  input  logic signed [11:0]    upper_limit,
  input  logic signed [11:0]    lower_limit,
  output logic                  out_valid,
  output fac_out_t              out_data
);

  lim_ctl_t            ctl5_r;
  logic                v5_r;
  logic [PROD_W-1:0]   prod5_r;

  logic [QUO_W-1:0]    quo;
  fac_out_t            res_nxt;

  logic                v6_r;
  fac_out_t            res6_r;

  always_comb begin
    quo = prod5_r[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
    if (ctl5_r.hi_hit) begin
      res_nxt.accel_command = upper_limit;
      res_nxt.limited       = 1'b1;
    end else if (ctl5_r.lo_hit) begin
      res_nxt.accel_command = lower_limit;
      res_nxt.limited       = 1'b1;
    end else begin
      res_nxt.accel_command = ctl5_r.neg ? signed'(-quo) : signed'(quo);
      res_nxt.limited       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v5_r <= ctl_in.valid;
      v6_r <= v5_r;
    end
    ctl5_r  <= ctl_in;
    prod5_r <= dividend * RECIP_78125;
    res6_r  <= res_nxt;
  end

  assign out_valid = v6_r;
  assign out_data  = res6_r;

endmodule

FILE: design/follower_accel_command_unit.sv
// Follower acceleration command: a six-stage pipeline from sample to clamped command.
//
// Each transaction is one sample; the block takes a new one on every clock (busy stays low)
// and delivers its command on out_valid, one result per sample and in order. The six
// register stages are: gap error and gain sum, feedback and feedforward products,
// feedforward sum, limit compare, reciprocal divide to the 0.01 m/s^2 LSB, and output
// selection. The result is shown for one cycle only; the receiver cannot stall it and
// must take it. Write configuration only while no sample is in flight.
module follower_accel_command_unit import fac_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  fac_in_t           in_data,
  output logic              out_valid,
  output fac_out_t          out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  logic [15:0]        desired_gap_r;
  logic signed [11:0] upper_limit_r;
  logic signed [11:0] lower_limit_r;

  logic                    in_valid;
  front_ctl_t              front_ctl;
  logic signed [VAL_W-1:0] base;
  logic [TERM_W-1:0]       lin_term, sq_term;
  lim_ctl_t                lim_ctl;
  logic [DIV_IN_W-1:0]     dividend;

  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desired_gap_r <= DESIRED_GAP_RST;
      upper_limit_r <= UPPER_LIMIT_RST;
      lower_limit_r <= LOWER_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_IDX_DESIRED_GAP: desired_gap_r <= cfg_wdata[15:0];
        CFG_IDX_UPPER_LIMIT: upper_limit_r <= signed'(cfg_wdata[11:0]);
        CFG_IDX_LOWER_LIMIT: lower_limit_r <= signed'(cfg_wdata[11:0]);
        default: ;
      endcase
    end
  end

  fac_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .desired_gap (desired_gap_r),
    .ctl         (front_ctl),
    .base        (base),
    .lin_term    (lin_term),
    .sq_term     (sq_term)
  );

  fac_limit u_limit (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl_in      (front_ctl),
    .base        (base),
    .lin_term    (lin_term),
    .sq_term     (sq_term),
    .upper_limit (upper_limit_r),
    .lower_limit (lower_limit_r),
    .ctl_out     (lim_ctl),
    .dividend    (dividend)
  );

  fac_round u_round (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl_in      (lim_ctl),
    .dividend    (dividend),
    .upper_limit (upper_limit_r),
    .lower_limit (lower_limit_r),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule

FILE: tb/fac_command_checker.sv
// Checker for the follower acceleration command unit: predicts each command and compares.
module fac_command_checker import fac_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  fac_in_t          in_data,
  input  logic             out_valid,
  input  fac_out_t         out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               pending,
  output int               checked_count,
  output int               clamped_count
);

  // Internal value unit: 1e-8 of one 0.01 m/s^2 step
  localparam longint FRAC_ONE = 100000000;

  logic [15:0]        gap_setpoint;
  logic signed [11:0] upper_lim;
  logic signed [11:0] lower_lim;
  fac_out_t           predicted_cmds[$];

  function automatic fac_out_t predict_command(fac_in_t s);
    longint   gap_err;
    longint   speed_diff;
    longint   accel;
    longint   brake;
    longint   pedal;
    longint   hi;
    longint   lo;
    longint   wsum;
    longint   v;
    longint   mag;
    longint   q;
    fac_out_t r;
    accel      = longint'(s.leader_accel);
    speed_diff = longint'(s.lead_vel) - longint'(s.own_vel);
    gap_err    = longint'(s.gap_distance) - longint'(gap_setpoint);
    brake      = longint'(s.brake_pedal);
    pedal      = longint'(s.accel_pedal);
    hi         = longint'(upper_lim);
    lo         = longint'(lower_lim);
    // Band gains are twice the outer ones except the gap gain, which is halved
    if (gap_err < 1000 && gap_err > -500)
      wsum = 4 * accel + 2 * speed_diff + 2 * gap_err;
    else
      wsum = 2 * accel + speed_diff + 4 * gap_err;
    v = wsum * (FRAC_ONE / 40);
    if (v < 0)
      v = v * 4;
    // Any brake at all blocks the accelerator feedforward
    if (brake > 0) begin
      if (brake > 1000 && brake < 5000)
        v = v - (1800000 * brake + 240 * brake * brake);
      else if (brake >= 5000)
        v = v - 3000000 * brake;
    end else if (pedal > 1000) begin
      v = v + 1200000 * pedal + 120 * pedal * pedal;
    end
    r.limited = 1'b0;
    if (v > hi * FRAC_ONE) begin
      q         = hi;
      r.limited = 1'b1;
    end else if (v < lo * FRAC_ONE) begin
      q         = lo;
      r.limited = 1'b1;
    end else begin
      // Round half away from zero
      mag = (v < 0) ? -v : v;
      q   = (mag + FRAC_ONE / 2) / FRAC_ONE;
      if (v < 0)
        q = -q;
    end
    r.accel_command = q[11:0];
    return r;
  endfunction

  initial begin
    fail_count    = 0;
    pending       = 0;
    checked_count = 0;
    clamped_count = 0;
  end

  always @(posedge clk) begin : watch
    fac_out_t want;
    if (!rst_n) begin
      gap_setpoint = DESIRED_GAP_RST;
      upper_lim    = UPPER_LIMIT_RST;
      lower_lim    = LOWER_LIMIT_RST;
      predicted_cmds.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_IDX_DESIRED_GAP: gap_setpoint = cfg_wdata[15:0];
          CFG_IDX_UPPER_LIMIT: upper_lim    = cfg_wdata[11:0];
          CFG_IDX_LOWER_LIMIT: lower_lim    = cfg_wdata[11:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (predicted_cmds.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected command %0d limited %0b", $time,
                   out_data.accel_command, out_data.limited);
        end else begin
          want = predicted_cmds.pop_front();
          checked_count++;
          if (want.limited)
            clamped_count++;
          if (out_data.accel_command !== want.accel_command) begin
            fail_count++;
            $display("%0t: accel_command expected %0d actual %0d", $time,
                     want.accel_command, out_data.accel_command);
          end
          if (out_data.limited !== want.limited) begin
            fail_count++;
            $display("%0t: limited expected %0b actual %0b", $time,
                     want.limited, out_data.limited);
          end
        end
      end
      if (start && !busy)
        predicted_cmds.push_back(predict_command(in_data));
    end
    pending = predicted_cmds.size();
  end

endmodule

FILE: tb/follower_accel_command_unit_tb.sv
// Testbench top for the follower acceleration command unit: stimulus, settings and verdict.
module follower_accel_command_unit_tb import fac_pkg::*; ();

  localparam int ITEMS_PER_PHASE = 170;
  localparam int DRAIN_CYCLES    = 200;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  fac_in_t          in_data;
  logic             out_valid;
  fac_out_t         out_data;
  logic             cfg_we;
  logic [1:0]       cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  int          fail_count;
  int          pending;
  int          checked_count;
  int          clamped_count;
  int          drain_errors;
  int          settings_count;
  logic [15:0] cur_gap;

  follower_accel_command_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  fac_command_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .clamped_count (clamped_count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic fac_in_t make_sample(int ls, int fs, int la, int gap, int bp, int ap);
    fac_in_t s;
    s.lead_vel     = 14'(ls);
    s.own_vel      = 14'(fs);
    s.leader_accel = 12'(la);
    s.gap_distance = 16'(gap);
    s.brake_pedal  = 14'(bp);
    s.accel_pedal  = 14'(ap);
    return s;
  endfunction

  function automatic logic [13:0] random_pedal();
    logic [13:0] p;
    case ($urandom_range(0, 7))
      0, 1:    p = '0;
      2:       p = 14'($urandom_range(1, 1000));
      3:       p = 14'($urandom_range(1001, 4999));
      4:       p = 14'($urandom_range(5000, 10000));
      5: begin
        case ($urandom_range(0, 3))
          0:       p = 14'd1000;
          1:       p = 14'd1001;
          2:       p = 14'd4999;
          default: p = 14'd5000;
        endcase
      end
      6:       p = 14'($urandom_range(10001, 16383));
      default: p = 14'($urandom);
    endcase
    return p;
  endfunction

  function automatic fac_in_t random_sample();
    fac_in_t s;
    longint  g;
    int      off;
    if ($urandom_range(0, 4) == 0) begin
      // Raw noise across every bit of every field
      s.lead_vel     = 14'($urandom);
      s.own_vel      = 14'($urandom);
      s.leader_accel = 12'($urandom);
      s.gap_distance = 16'($urandom);
      s.brake_pedal  = 14'($urandom);
      s.accel_pedal  = 14'($urandom);
      return s;
    end
    case ($urandom_range(0, 3))
      0, 1: off = int'($urandom_range(0, 1498)) - 499;
      2: begin
        case ($urandom_range(0, 3))
          0:       off = -500;
          1:       off = -499;
          2:       off = 999;
          default: off = 1000;
        endcase
      end
      default: off = int'($urandom_range(0, 20000)) - 10000;
    endcase
    g = longint'(cur_gap) + off;
    if (g < 0)
      g = 0;
    if (g > 65535)
      g = 65535;
    s.lead_vel     = 14'($urandom_range(0, 10000));
    s.own_vel      = 14'($urandom_range(0, 10000));
    s.leader_accel = 12'(int'($urandom_range(0, 3000)) - 1500);
    s.gap_distance = 16'(g);
    s.brake_pedal  = ($urandom_range(0, 2) == 0) ? random_pedal() : '0;
    s.accel_pedal  = random_pedal();
    return s;
  endfunction

  // Hold start high until a rising edge sees busy low
  task automatic send_sample(input fac_in_t s);
    logic stalled;
    start   <= 1'b1;
    in_data <= s;
    do begin
      @(negedge clk);
      stalled = busy;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic program_regs(input logic [15:0] gap, input logic signed [11:0] hi,
                              input logic signed [11:0] lo);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_IDX_DESIRED_GAP;
    cfg_wdata <= gap;
    @(posedge clk);
    cfg_idx   <= CFG_IDX_UPPER_LIMIT;
    cfg_wdata <= {4'($urandom), hi};
    @(posedge clk);
    cfg_idx   <= CFG_IDX_LOWER_LIMIT;
    cfg_wdata <= {4'($urandom), lo};
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_gap  = gap;
    settings_count++;
  endtask

  task automatic run_bursts(input int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left)
        burst = left;
      repeat (burst) send_sample(random_sample());
      left -= burst;
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
  endtask

  // Drop start and wait for every predicted command to come out
  task automatic drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    do begin
      @(negedge clk);
      waited++;
    end while (pending != 0 && waited < DRAIN_CYCLES);
    if (pending != 0) begin
      drain_errors++;
      $display("%0t: %0d commands never appeared", $time, pending);
    end
    @(posedge clk);
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_IDX_DESIRED_GAP;
    cfg_wdata      = '0;
    drain_errors   = 0;
    settings_count = 1;
    cur_gap        = DESIRED_GAP_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: zero, clamps, field extremes, band edges, rounding, pedal regions
    send_sample(make_sample(0, 0, 0, 1500, 0, 0));
    send_sample(make_sample(10000, 0, 1500, 65535, 0, 0));
    send_sample(make_sample(0, 10000, -1500, 0, 0, 0));
    send_sample(make_sample(16383, 0, 2047, 1500, 0, 0));
    send_sample(make_sample(0, 16383, -2048, 1500, 0, 0));
    send_sample(make_sample(5000, 5000, 0, 1000, 0, 0));
    send_sample(make_sample(5000, 5000, 0, 1001, 0, 0));
    send_sample(make_sample(5000, 5000, 0, 2499, 0, 0));
    send_sample(make_sample(5000, 5000, 0, 2500, 0, 0));
    send_sample(make_sample(3000, 3000, 5, 1500, 0, 0));
    send_sample(make_sample(3000, 3000, 0, 1500, 5050, 0));
    send_sample(make_sample(3000, 3000, 0, 1500, 1, 8000));
    send_sample(make_sample(3000, 3000, 0, 1500, 1000, 8000));
    send_sample(make_sample(3000, 3000, 0, 1500, 1001, 0));
    send_sample(make_sample(3000, 3000, 0, 1500, 4999, 0));
    send_sample(make_sample(3000, 3000, 0, 1500, 5000, 0));
    send_sample(make_sample(3000, 3000, 0, 1500, 10000, 0));
    send_sample(make_sample(3000, 3000, 0, 1500, 16383, 16383));
    send_sample(make_sample(3000, 3000, 0, 1500, 0, 1000));
    send_sample(make_sample(3000, 3000, 0, 1500, 0, 1001));
    send_sample(make_sample(3000, 3000, 0, 1500, 0, 10000));
    send_sample(make_sample(3000, 3000, 0, 1500, 0, 16383));
    run_bursts(ITEMS_PER_PHASE);
    drain();

    program_regs(16'd0, 12'sd1500, -12'sd1500);
    run_bursts(ITEMS_PER_PHASE);
    drain();
    program_regs(16'd65535, 12'sd2047, -12'sd2048);
    run_bursts(ITEMS_PER_PHASE);
    drain();
    // Crossed limits: upper compare still wins
    program_regs(16'd3000, -12'sd100, 12'sd100);
    run_bursts(ITEMS_PER_PHASE);
    drain();
    program_regs(16'd1000, 12'sd0, 12'sd0);
    run_bursts(ITEMS_PER_PHASE);
    drain();
    program_regs(16'd1500, -12'sd1500, 12'sd1500);
    run_bursts(ITEMS_PER_PHASE);
    drain();
    repeat (2) begin
      program_regs(16'($urandom_range(0, 4000)), 12'($urandom_range(0, 1500)),
                   12'(-int'($urandom_range(0, 1500))));
      run_bursts(ITEMS_PER_PHASE);
      drain();
    end
    program_regs(16'($urandom), 12'($urandom), 12'($urandom));
    run_bursts(ITEMS_PER_PHASE);
    drain();

    repeat (12) @(posedge clk);
    $display("Checked %0d commands (%0d clamped) under %0d register settings,",
             checked_count, clamped_count, settings_count);
    $display("with random sender gaps and back-to-back bursts.");
    if (fail_count == 0 && drain_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: follower_accel_command_unit.f
design/fac_pkg.sv
design/fac_front.sv
design/fac_limit.sv
design/fac_round.sv
design/follower_accel_command_unit.sv
tb/fac_command_checker.sv
tb/follower_accel_command_unit_tb.sv
